@@ sv/ate_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the alarm table engine
// command codes and the controller to datapath command and status structs
// no dependencies
package ate_pkg;

  localparam logic [2:0] CMD_RAISE   = 3'd0;
  localparam logic [2:0] CMD_CLEAR   = 3'd1;
  localparam logic [2:0] CMD_ACK     = 3'd2;
  localparam logic [2:0] CMD_ACK_ALL = 3'd3;
  localparam logic [2:0] CMD_LOOKUP  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;          // latch the item, start the first pass
    logic search;        // read-only pass over the table
    logic rewrite_init;  // reset pointers for the rewrite pass
    logic rewrite;       // read, modify and compact pass
    logic append;        // write a new entry at the tail
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;     // every entry below the count has been handled
    logic need_search;
    logic need_rewrite;
    logic need_append;
  } dp_status_t;

endpackage

@@ sv/ate_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module ate_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ate_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine for the alarm table engine
// sequences search, rewrite and append passes; uses ate_pkg
module ate_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ate_pkg::dp_status_t sts,
  output ate_pkg::dp_cmd_t    ctl,
  output logic                busy,
  output logic                done
);

  import ate_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SEARCH  = 5'b00010,
    S_REWRITE = 5'b00100,
    S_APPEND  = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctl.search = sts.need_search;
        if (!sts.need_search || sts.scan_done) begin
          if (sts.need_rewrite) begin
            ctl.rewrite_init = 1'b1;
            state_next       = S_REWRITE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_REWRITE: begin
        ctl.rewrite = 1'b1;
        if (sts.scan_done) begin
          state_next = sts.need_append ? S_APPEND : S_DONE;
        end
      end
      S_APPEND: begin
        ctl.append = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

@@ sv/ate_datapath.sv @@
`timescale 1ns / 1ps
// datapath for the alarm table engine: entry ram, scan pointers, match and
// summary registers; uses ate_pkg and ate_ram
module ate_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ate_pkg::dp_cmd_t    ctl,
  output ate_pkg::dp_status_t sts,
  input  logic [2:0]          command,
  input  logic [15:0]         alarm_code,
  input  logic                severity,
  input  logic [31:0]         now_seconds,
  input  logic                auto_clear,
  output logic                code_found,
  output logic                match_severity,
  output logic                match_active,
  output logic                match_acked,
  output logic [31:0]         match_raised_at,
  output logic                any_active,
  output logic                any_active_critical,
  output logic                any_unacked,
  output logic                overflow_seen,
  output logic [4:0]          entry_count
);

  import ate_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);

  typedef struct packed {
    logic [15:0] code;
    logic        sev;
    logic [31:0] raised;
    logic        active;
    logic        acked;
    logic        self_clr;
  } entry_t;

  // latched item
  logic [2:0]  cmd_q;
  logic [15:0] code_q;
  logic        sev_q;
  logic [31:0] now_q;
  logic        selfclr_q;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic             drop_oldest;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic [CNT_W-1:0] wr_ptr;

  logic             found;
  logic [CNT_W-1:0] match_idx;
  logic             m_sev, m_act, m_ack;
  logic [31:0]      m_time;
  logic             act, crit, unack;

  logic   ram_we;
  entry_t ram_wdata, ram_rdata, upd, new_entry;

  logic rd_issue, is_raise, code_hit, hit, keep, rw_write, drop_next, match_ok;

  assign rd_issue  = (ctl.search || ctl.rewrite) && (rd_ptr < count);
  assign is_raise  = (cmd_q == CMD_RAISE);
  assign code_hit  = (ram_rdata.code == code_q);
  // raise knows its index from the search; the others take the first match
  assign hit       = is_raise ? (found && (rd_idx == match_idx)) : (!found && code_hit);
  assign drop_next = is_raise && !found && (count == FULL);

  always_comb begin
    upd  = ram_rdata;
    keep = 1'b1;
    case (cmd_q)
      CMD_RAISE: begin
        if (hit) begin
          if (!ram_rdata.active) begin
            upd.active = 1'b1;
            upd.acked  = 1'b0;
            upd.raised = now_q;
          end
          upd.sev      = sev_q;
          upd.self_clr = selfclr_q;
        end
        if (drop_oldest && (rd_idx == '0)) begin
          keep = 1'b0;
        end
      end
      CMD_CLEAR: begin
        if (hit) begin
          if (ram_rdata.acked || ram_rdata.self_clr) begin
            keep = 1'b0;
          end else begin
            upd.active = 1'b0;
          end
        end
      end
      CMD_ACK: begin
        if (hit) begin
          if (ram_rdata.active) begin
            upd.acked = 1'b1;
          end else begin
            keep = 1'b0;
          end
        end
      end
      CMD_ACK_ALL: begin
        if (ram_rdata.active) begin
          upd.acked = 1'b1;
        end else begin
          keep = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign new_entry = '{code: code_q, sev: sev_q, raised: now_q, active: 1'b1,
                       acked: 1'b0, self_clr: selfclr_q};
  assign rw_write  = ctl.rewrite && rd_pend && keep;
  assign ram_we    = rw_write || ctl.append;
  assign ram_wdata = ctl.append ? new_entry : upd;

  ate_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (ctl.rewrite_init && drop_next) begin
        overflow <= 1'b1;
      end
      if (ctl.rewrite && sts.scan_done) begin
        count <= wr_ptr;
      end
      if (ctl.append) begin
        count <= wr_ptr + 1'b1;
      end
    end
  end

  // pointers, match and summary
  always_ff @(posedge clk) begin
    rd_idx <= rd_ptr;
    if (rd_issue) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
    if (ctl.search && rd_pend) begin
      if (ram_rdata.active) begin
        act <= 1'b1;
        if (ram_rdata.sev) begin
          crit <= 1'b1;
        end
      end
      if (!ram_rdata.acked) begin
        unack <= 1'b1;
      end
      if (!found && code_hit) begin
        found     <= 1'b1;
        match_idx <= rd_idx;
        m_sev     <= ram_rdata.sev;
        m_act     <= ram_rdata.active;
        m_ack     <= ram_rdata.acked;
        m_time    <= ram_rdata.raised;
      end
    end
    if (ctl.rewrite && rd_pend) begin
      if (keep) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (upd.active) begin
          act <= 1'b1;
          if (upd.sev) begin
            crit <= 1'b1;
          end
        end
        if (!upd.acked) begin
          unack <= 1'b1;
        end
      end
      // ack reports the entry as it stands after the ack
      if (hit && !is_raise) begin
        found  <= 1'b1;
        m_sev  <= upd.sev;
        m_act  <= upd.active;
        m_ack  <= upd.acked;
        m_time <= upd.raised;
      end
    end
    if (ctl.append) begin
      wr_ptr <= wr_ptr + 1'b1;
      act    <= 1'b1;
      crit   <= crit | sev_q;
      unack  <= 1'b1;
    end
    if (ctl.rewrite_init) begin
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      act         <= 1'b0;
      crit        <= 1'b0;
      unack       <= 1'b0;
      drop_oldest <= drop_next;
    end
    if (ctl.load) begin
      cmd_q     <= command;
      code_q    <= alarm_code;
      sev_q     <= severity;
      now_q     <= now_seconds;
      selfclr_q <= auto_clear;
      rd_ptr    <= '0;
      found     <= 1'b0;
      act       <= 1'b0;
      crit      <= 1'b0;
      unack     <= 1'b0;
    end
  end

  assign sts.scan_done    = !(rd_ptr < count) && !rd_pend;
  assign sts.need_rewrite = (cmd_q == CMD_RAISE) || (cmd_q == CMD_CLEAR) ||
                            (cmd_q == CMD_ACK) || (cmd_q == CMD_ACK_ALL);
  assign sts.need_search  = is_raise || !sts.need_rewrite;
  assign sts.need_append  = is_raise && !found;

  assign match_ok            = found && ((cmd_q == CMD_ACK) || (cmd_q == CMD_LOOKUP));
  assign code_found          = match_ok;
  assign match_severity      = match_ok & m_sev;
  assign match_active        = match_ok & m_act;
  assign match_acked         = match_ok & m_ack;
  assign match_raised_at     = match_ok ? m_time : 32'd0;
  assign any_active          = act;
  assign any_active_critical = crit;
  assign any_unacked         = unack;
  assign overflow_seen       = overflow;
  assign entry_count         = 5'(count);

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count above table size");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    rw_write |-> (wr_ptr <= rd_idx))
    else $error("compaction write overtook the read side");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag cleared without reset");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    ctl.append |-> (wr_ptr < FULL))
    else $error("append with no free entry");
`endif

endmodule

@@ sv/alarm_table_engine.sv @@
`timescale 1ns / 1ps
// top level of the alarm table engine
// joins ate_ctrl and ate_datapath; uses ate_pkg
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  item in  | start && !busy          | command alarm_code severity
//           |                         | now_seconds auto_clear
//  result   | done, one cycle         | code_found match_* any_* overflow_seen
//           |                         | entry_count
//
// from the accepting edge to the done edge a raise runs a search pass, a
// rewrite pass and, when the code is absent, an append; clear, ack and
// ack-all run only the rewrite pass and lookup only the search pass; their
// length is set by the entry ram, read one entry per cycle in a search pass
// and again in a rewrite pass that compacts entries in place through its
// write port. busy stays high from the accepting edge to the done cycle; the
// next item can be taken in the cycle after done; done lasts one cycle and the
// receiver cannot stall it.
// reset is synchronous and empties the table; entry contents need no clear.
module alarm_table_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [15:0] alarm_code,
  input  logic        severity,
  input  logic [31:0] now_seconds,
  input  logic        auto_clear,
  output logic        done,
  output logic        code_found,
  output logic        match_severity,
  output logic        match_active,
  output logic        match_acked,
  output logic [31:0] match_raised_at,
  output logic        any_active,
  output logic        any_active_critical,
  output logic        any_unacked,
  output logic        overflow_seen,
  output logic [4:0]  entry_count
);

  import ate_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t    ctl;
  dp_status_t sts;

  // controller: idle, search, rewrite, append, done
  ate_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // datapath: entry ram, scan pointers, match and summary registers
  ate_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .sts                 (sts),
    .command             (command),
    .alarm_code          (alarm_code),
    .severity            (severity),
    .now_seconds         (now_seconds),
    .auto_clear          (auto_clear),
    .code_found          (code_found),
    .match_severity      (match_severity),
    .match_active        (match_active),
    .match_acked         (match_acked),
    .match_raised_at     (match_raised_at),
    .any_active          (any_active),
    .any_active_critical (any_active_critical),
    .any_unacked         (any_unacked),
    .overflow_seen       (overflow_seen),
    .entry_count         (entry_count)
  );

endmodule
